### design/ckre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_pkg
// Shared types and constants of the colour-key run extractor.
// ----------------------------------------------------------------------------
package ckre_pkg;

  localparam int CKRE_MAX_WIDTH  = 4096;
  localparam int CKRE_MAX_HEIGHT = 4096;
  localparam int CHAN_W          = 8;
  localparam int DIM_W           = 13;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [DIM_W-1:0]  DIM_ALL_ONES = {DIM_W{1'b1}};
  localparam logic [CHAN_W-1:0] CHAN_MAX     = {CHAN_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE_BLUE  = 3'd4;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_BOX = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } ckre_pix_t;

  typedef struct packed {
    logic             kind;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] bottom;
    logic             empty_res;
    logic             last;
  } ckre_res_t;

  // classification of one pixel, front to back
  typedef struct packed {
    logic transparent;
    logic row_end;
    logic frame_end;
  } ckre_cls_t;

endpackage : ckre_pkg
`default_nettype wire

### design/color_key_run_extractor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_key_run_extractor_core
// Colour-key run extractor: opaque runs and frame bounding box from pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order, unless in_full holds it off.
// The first pixel of each frame sets the key; every horizontal run of
// opaque pixels gives one rectangle, and the last pixel of the frame also
// gives the bounding box. The front stage classifies a pixel in the cycle
// it is accepted and hands it through a four-item queue to the back stage,
// which writes results into a four-item output queue. The back stage takes
// one pixel per cycle while the output queue has room, but stops for the
// second result of a frame that ends on an open run. A result reaches the
// output ports through the pixel queue and the output queue.
// ----------------------------------------------------------------------------
module color_key_run_extractor_core import ckre_pkg::*; #(
  parameter int MAX_WIDTH  = CKRE_MAX_WIDTH,
  parameter int MAX_HEIGHT = CKRE_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire ckre_pix_t            in_data,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output ckre_res_t                 out_data
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RECW = $bits(ckre_cls_t) + CW + RW;

  logic            rec_push, rec_pop, rec_full, rec_empty;
  ckre_cls_t       f_cls, b_cls;
  logic [CW-1:0]   f_col, b_col;
  logic [RW-1:0]   f_row, b_row;
  logic [RECW-1:0] rec_rd;
  logic            res_push, res_full, box_pend;
  ckre_res_t       res_data;

  assign cfg_ready = 1'b1;
  assign in_full   = rec_full;

  ckre_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_push  (in_push),
    .pix       (in_data),
    .q_full    (rec_full),
    .rec_push  (rec_push),
    .rec_cls   (f_cls),
    .rec_col   (f_col),
    .rec_row   (f_row)
  );

  ckre_fifo #(
    .WIDTH (RECW),
    .DEPTH (QUEUE_DEPTH)
  ) u_rec_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rec_push),
    .wr_data ({f_cls, f_col, f_row}),
    .full    (rec_full),
    .pop     (rec_pop),
    .rd_data (rec_rd),
    .empty   (rec_empty)
  );

  assign {b_cls, b_col, b_row} = rec_rd;

  ckre_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (rec_empty),
    .rec_cls   (b_cls),
    .rec_col   (b_col),
    .rec_row   (b_row),
    .rec_pop   (rec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .box_pend  (box_pend)
  );

  ckre_fifo #(
    .WIDTH ($bits(ckre_res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rec_pop |-> !rec_empty)
    else $error("pixel record taken from an empty queue");

  a_box_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_data.kind == KIND_BOX) |-> res_data.last)
    else $error("bounding box not marked last");

  a_pend_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    box_pend |-> !rec_pop)
    else $error("record taken while bounding box pending");

endmodule : color_key_run_extractor_core
`default_nettype wire

### design/ckre_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_fifo
// Small register queue with show-ahead read.
// ----------------------------------------------------------------------------
module ckre_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule : ckre_fifo
`default_nettype wire

### design/ckre_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_front
// Config registers, raster position, key capture and pixel classification.
// ----------------------------------------------------------------------------
module ckre_front import ckre_pkg::*; #(
  parameter int MAX_WIDTH  = CKRE_MAX_WIDTH,
  parameter int MAX_HEIGHT = CKRE_MAX_HEIGHT,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int SW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W,
  localparam int SH = (RW + 1 > DIM_W) ? RW + 1 : DIM_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 pix_push,
  input  wire ckre_pix_t            pix,
  input  wire logic                 q_full,
  output logic                      rec_push,
  output ckre_cls_t                 rec_cls,
  output logic [CW-1:0]             rec_col,
  output logic [RW-1:0]             rec_row
);

  logic [DIM_W-1:0]  width_r, height_r;
  logic [CHAN_W-1:0] tol_r    [3];
  logic [CHAN_W-1:0] key_lo_r [3];
  logic [CHAN_W-1:0] key_hi_r [3];
  logic [CW-1:0]     column_r, column_nxt;
  logic [RW-1:0]     row_r, row_nxt;

  logic [CHAN_W-1:0] chan    [3];
  logic [CHAN_W-1:0] band_lo [3];
  logic [CHAN_W-1:0] band_hi [3];
  logic [CHAN_W:0]   band_sum [3];
  logic [2:0]        in_band;
  logic              first;
  logic [SW-1:0]     w_eff, col_inc;
  logic [SH-1:0]     h_eff, row_inc;
  logic              accept;

  assign chan[0] = pix.red;
  assign chan[1] = pix.green;
  assign chan[2] = pix.blue;
  assign accept  = pix_push && !q_full;
  assign first   = (column_r == '0) && (row_r == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      band_lo[i]  = (chan[i] > tol_r[i]) ? chan[i] - tol_r[i] : '0;
      band_sum[i] = {1'b0, chan[i]} + {1'b0, tol_r[i]};
      band_hi[i]  = band_sum[i][CHAN_W] ? CHAN_MAX : band_sum[i][CHAN_W-1:0];
      in_band[i]  = (chan[i] >= key_lo_r[i]) && (chan[i] <= key_hi_r[i]);
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = SW'(1);
    end else if (SW'(width_r) > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SH'(1);
    end else if (SH'(height_r) > SH'(MAX_HEIGHT)) begin
      h_eff = SH'(MAX_HEIGHT);
    end else begin
      h_eff = SH'(height_r);
    end
  end

  assign col_inc = SW'(column_r) + 1'b1;
  assign row_inc = SH'(row_r) + 1'b1;

  // the key pixel always lies inside its own band
  assign rec_cls.transparent = first || (&in_band);
  assign rec_cls.row_end     = (col_inc >= w_eff);
  assign rec_cls.frame_end   = rec_cls.row_end && (row_inc >= h_eff);
  assign rec_col             = column_r;
  assign rec_row             = row_r;
  assign rec_push            = accept;

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    if (accept) begin
      if (rec_cls.frame_end) begin
        column_nxt = '0;
        row_nxt    = '0;
      end else if (rec_cls.row_end) begin
        column_nxt = '0;
        row_nxt    = RW'(row_inc);
      end else begin
        column_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(CKRE_MAX_WIDTH);
      height_r <= DIM_W'(CKRE_MAX_HEIGHT);
      column_r <= '0;
      row_r    <= '0;
      for (int i = 0; i < 3; i++) begin
        tol_r[i]    <= '0;
        key_lo_r[i] <= '0;
        key_hi_r[i] <= '0;
      end
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      if (cfg_wr) begin
        case (cfg_index)
          REG_FRAME_WIDTH:     width_r  <= cfg_data;
          REG_FRAME_HEIGHT:    height_r <= cfg_data;
          REG_TOLERANCE_RED:   tol_r[0] <= cfg_data[CHAN_W-1:0];
          REG_TOLERANCE_GREEN: tol_r[1] <= cfg_data[CHAN_W-1:0];
          REG_TOLERANCE_BLUE:  tol_r[2] <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (accept && first) begin
        for (int i = 0; i < 3; i++) begin
          key_lo_r[i] <= band_lo[i];
          key_hi_r[i] <= band_hi[i];
        end
      end
    end
  end

endmodule : ckre_front
`default_nettype wire

### design/ckre_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_back
// Run tracking, bounding box accumulation and result generation.
// ----------------------------------------------------------------------------
module ckre_back import ckre_pkg::*; #(
  parameter int MAX_WIDTH  = CKRE_MAX_WIDTH,
  parameter int MAX_HEIGHT = CKRE_MAX_HEIGHT,
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int BLW = (CW > DIM_W) ? CW : DIM_W,
  localparam int BTW = (RW > DIM_W) ? RW : DIM_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rec_empty,
  input  wire ckre_cls_t     rec_cls,
  input  wire logic [CW-1:0] rec_col,
  input  wire logic [RW-1:0] rec_row,
  output logic               rec_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output ckre_res_t          res_data,
  output logic               box_pend
);

  logic           in_run_r, in_run_nxt;
  logic [CW-1:0]  run_start_r, run_start_nxt;
  logic [BLW-1:0] box_left_r, box_left_nxt;
  logic [BTW-1:0] box_top_r, box_top_nxt;
  logic [CW:0]    box_right_r, box_right_nxt;
  logic [RW:0]    box_bottom_r, box_bottom_nxt;
  logic           any_run_r, any_run_nxt;
  logic           pend_r, pend_nxt;

  logic           close;
  logic [CW-1:0]  start;
  logic [CW:0]    run_end;
  logic [RW:0]    row_inc;
  ckre_res_t      box_res;
  logic           clear;

  assign row_inc  = {1'b0, rec_row} + 1'b1;
  assign start    = in_run_r ? run_start_r : rec_col;
  assign box_pend = pend_r;

  always_comb begin
    box_res.kind      = KIND_BOX;
    box_res.left      = any_run_r ? DIM_W'(box_left_r) : '0;
    box_res.top       = any_run_r ? DIM_W'(box_top_r) : '0;
    box_res.right     = any_run_r ? DIM_W'(box_right_r) : '0;
    box_res.bottom    = any_run_r ? DIM_W'(box_bottom_r) : '0;
    box_res.empty_res = !any_run_r;
    box_res.last      = 1'b1;
  end

  always_comb begin
    in_run_nxt     = in_run_r;
    run_start_nxt  = run_start_r;
    box_left_nxt   = box_left_r;
    box_top_nxt    = box_top_r;
    box_right_nxt  = box_right_r;
    box_bottom_nxt = box_bottom_r;
    any_run_nxt    = any_run_r;
    pend_nxt       = pend_r;
    rec_pop        = 1'b0;
    res_push       = 1'b0;
    res_data       = box_res;
    close          = 1'b0;
    run_end        = {1'b0, rec_col};
    clear          = 1'b0;

    if (pend_r) begin
      // second result of a frame that ended on a run
      if (!res_full) begin
        res_push = 1'b1;
        pend_nxt = 1'b0;
        clear    = 1'b1;
      end
    end else if (!rec_empty && !res_full) begin
      rec_pop = 1'b1;
      if (rec_cls.transparent) begin
        close   = in_run_r;
        run_end = {1'b0, rec_col};
      end else begin
        close         = rec_cls.row_end;
        run_end       = {1'b0, rec_col} + 1'b1;
        in_run_nxt    = 1'b1;
        run_start_nxt = start;
      end
      if (close) begin
        res_push           = 1'b1;
        res_data.kind      = KIND_RUN;
        res_data.left      = DIM_W'(start);
        res_data.top       = DIM_W'(rec_row);
        res_data.right     = DIM_W'(run_end);
        res_data.bottom    = DIM_W'(row_inc);
        res_data.empty_res = 1'b0;
        res_data.last      = !rec_cls.frame_end;
        if (BLW'(start) < box_left_r) begin
          box_left_nxt = BLW'(start);
        end
        if (BTW'(rec_row) < box_top_r) begin
          box_top_nxt = BTW'(rec_row);
        end
        if (run_end > box_right_r) begin
          box_right_nxt = run_end;
        end
        if (row_inc > box_bottom_r) begin
          box_bottom_nxt = row_inc;
        end
        any_run_nxt = 1'b1;
        in_run_nxt  = 1'b0;
        pend_nxt    = rec_cls.frame_end;
      end else if (rec_cls.frame_end) begin
        res_push = 1'b1;
        clear    = 1'b1;
      end
      if (rec_cls.row_end) begin
        in_run_nxt = 1'b0;
      end
    end

    if (clear) begin
      in_run_nxt     = 1'b0;
      run_start_nxt  = '0;
      box_left_nxt   = BLW'(DIM_ALL_ONES);
      box_top_nxt    = BTW'(DIM_ALL_ONES);
      box_right_nxt  = '0;
      box_bottom_nxt = '0;
      any_run_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r     <= 1'b0;
      run_start_r  <= '0;
      box_left_r   <= BLW'(DIM_ALL_ONES);
      box_top_r    <= BTW'(DIM_ALL_ONES);
      box_right_r  <= '0;
      box_bottom_r <= '0;
      any_run_r    <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      in_run_r     <= in_run_nxt;
      run_start_r  <= run_start_nxt;
      box_left_r   <= box_left_nxt;
      box_top_r    <= box_top_nxt;
      box_right_r  <= box_right_nxt;
      box_bottom_r <= box_bottom_nxt;
      any_run_r    <= any_run_nxt;
      pend_r       <= pend_nxt;
    end
  end

endmodule : ckre_back
`default_nettype wire

### tb/color_key_run_extractor_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_key_run_extractor_core_test
// Self-checking bench for the colour-key run extractor core.
// ----------------------------------------------------------------------------
// Pixels go in through the push/full queue port. Each accepted item is also
// run through a local model of the run and bounding-box logic, and the
// rectangles it yields are queued. Every popped result is checked field by
// field against the head of that queue. Registers are written only once all
// expected rectangles have been popped and the pipeline has run dry. The
// frame may still be open at that point, so mid-frame resizes and tolerance
// changes are covered too. Both sides stall at random, but for the first
// QUIET_ITEMS pixels of the random frames.
module color_key_run_extractor_core_test;
  import ckre_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int PIPE_FLUSH    = 16;
  localparam int RANDOM_ITEMS  = 620;
  localparam int QUIET_ITEMS   = 200;
  localparam int OVER_ITEMS    = 24;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef enum {CH_INSIDE, CH_EDGE, CH_OUTSIDE, CH_ANY} chan_pick_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  ckre_pix_t            in_data   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  ckre_res_t            out_data;

  color_key_run_extractor_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // local copy of registers and frame state
  logic [DIM_W-1:0]  reg_width  = DIM_W'(CKRE_MAX_WIDTH);
  logic [DIM_W-1:0]  reg_height = DIM_W'(CKRE_MAX_HEIGHT);
  logic [CHAN_W-1:0] reg_tol_r  = '0;
  logic [CHAN_W-1:0] reg_tol_g  = '0;
  logic [CHAN_W-1:0] reg_tol_b  = '0;
  logic [CHAN_W-1:0] band_lo_r = '0, band_hi_r = '0;
  logic [CHAN_W-1:0] band_lo_g = '0, band_hi_g = '0;
  logic [CHAN_W-1:0] band_lo_b = '0, band_hi_b = '0;
  logic [11:0]       cur_col  = '0;
  logic [11:0]       cur_row  = '0;
  logic [11:0]       run_from = '0;
  logic              run_open = 1'b0;
  logic              saw_run  = 1'b0;
  logic [DIM_W-1:0]  box_l = DIM_ALL_ONES, box_t = DIM_ALL_ONES;
  logic [DIM_W-1:0]  box_r = '0, box_b = '0;

  ckre_res_t pending_regions[$];

  int stall_pct = 9;
  int n_fail    = 0;
  int n_pixels  = 0;
  int n_runs    = 0;
  int n_boxes   = 0;

  function automatic logic [CHAN_W-1:0] band_floor(logic [CHAN_W-1:0] k, logic [CHAN_W-1:0] t);
    return (k > t) ? k - t : '0;
  endfunction

  function automatic logic [CHAN_W-1:0] band_ceil(logic [CHAN_W-1:0] k, logic [CHAN_W-1:0] t);
    logic [CHAN_W:0] s;
    s = {1'b0, k} + {1'b0, t};
    return s[CHAN_W] ? CHAN_MAX : s[CHAN_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == '0) return DIM_W'(1);
    if (int'(v) > maxv) return DIM_W'(maxv);
    return v;
  endfunction

  function automatic logic at_frame_start();
    return cur_col == '0 && cur_row == '0;
  endfunction

  function automatic ckre_res_t close_run(logic [DIM_W-1:0] end_col);
    ckre_res_t r;
    logic [DIM_W-1:0] row_top, row_next, col_from;
    row_top  = {1'b0, cur_row};
    row_next = row_top + DIM_W'(1);
    col_from = {1'b0, run_from};
    r        = '0;
    r.kind   = KIND_RUN;
    r.left   = col_from;
    r.top    = row_top;
    r.right  = end_col;
    r.bottom = row_next;
    if (col_from < box_l) box_l = col_from;
    if (row_top < box_t) box_t = row_top;
    if (end_col > box_r) box_r = end_col;
    if (row_next > box_b) box_b = row_next;
    saw_run  = 1'b1;
    run_open = 1'b0;
    return r;
  endfunction

  function automatic void predict_pixel(ckre_pix_t p);
    ckre_res_t        res[2];
    int               n;
    logic [DIM_W-1:0] w, h, col13;
    logic             transparent, row_end, frame_end;
    n = 0;
    w = clamp_dim(reg_width, CKRE_MAX_WIDTH);
    h = clamp_dim(reg_height, CKRE_MAX_HEIGHT);
    if (at_frame_start()) begin
      band_lo_r = band_floor(p.red, reg_tol_r);
      band_hi_r = band_ceil(p.red, reg_tol_r);
      band_lo_g = band_floor(p.green, reg_tol_g);
      band_hi_g = band_ceil(p.green, reg_tol_g);
      band_lo_b = band_floor(p.blue, reg_tol_b);
      band_hi_b = band_ceil(p.blue, reg_tol_b);
    end
    transparent = p.red >= band_lo_r && p.red <= band_hi_r &&
                  p.green >= band_lo_g && p.green <= band_hi_g &&
                  p.blue >= band_lo_b && p.blue <= band_hi_b;
    col13     = {1'b0, cur_col};
    row_end   = col13 + DIM_W'(1) >= w;
    frame_end = row_end && ({1'b0, cur_row} + DIM_W'(1) >= h);
    if (transparent) begin
      if (run_open) begin
        res[n] = close_run(col13);
        n++;
      end
    end else begin
      if (!run_open) begin
        run_from = cur_col;
        run_open = 1'b1;
      end
      if (row_end) begin
        res[n] = close_run(col13 + DIM_W'(1));
        n++;
      end
    end
    if (frame_end) begin
      res[n]      = '0;
      res[n].kind = KIND_BOX;
      if (saw_run) begin
        res[n].left   = box_l;
        res[n].top    = box_t;
        res[n].right  = box_r;
        res[n].bottom = box_b;
      end else begin
        res[n].empty_res = 1'b1;
      end
      n++;
      cur_col  = '0;
      cur_row  = '0;
      run_from = '0;
      run_open = 1'b0;
      saw_run  = 1'b0;
      box_l    = DIM_ALL_ONES;
      box_t    = DIM_ALL_ONES;
      box_r    = '0;
      box_b    = '0;
    end else if (row_end) begin
      run_open = 1'b0;
      cur_col  = '0;
      cur_row  = cur_row + 12'd1;
    end else begin
      cur_col = cur_col + 12'd1;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_regions.push_back(res[i]);
  endfunction

  function automatic void compare_field(string name, logic [DIM_W-1:0] want,
                                        logic [DIM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : check_result
    ckre_res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_regions.size() == 0) begin
        $error("result with nothing expected: kind %0d left %0d top %0d", out_data.kind,
               out_data.left, out_data.top);
        n_fail++;
      end else begin
        want = pending_regions.pop_front();
        compare_field("kind", {12'b0, want.kind}, {12'b0, out_data.kind});
        compare_field("left", want.left, out_data.left);
        compare_field("top", want.top, out_data.top);
        compare_field("right", want.right, out_data.right);
        compare_field("bottom", want.bottom, out_data.bottom);
        compare_field("empty_res", {12'b0, want.empty_res}, {12'b0, out_data.empty_res});
        compare_field("last", {12'b0, want.last}, {12'b0, out_data.last});
        if (want.kind == KIND_BOX) n_boxes++;
        else n_runs++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_pixel(ckre_pix_t p);
    if ($urandom_range(99) < stall_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_full);
    predict_pixel(p);
    n_pixels++;
  endtask

  // hold off the sender until every expected item is out and the pipe is dry
  task automatic settle();
    in_push <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:     reg_width  = data;
      REG_FRAME_HEIGHT:    reg_height = data;
      REG_TOLERANCE_RED:   reg_tol_r  = data[CHAN_W-1:0];
      REG_TOLERANCE_GREEN: reg_tol_g  = data[CHAN_W-1:0];
      REG_TOLERANCE_BLUE:  reg_tol_b  = data[CHAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [DIM_W-1:0] frame_w, logic [DIM_W-1:0] frame_h,
                           logic [CHAN_W-1:0] tol_r, logic [CHAN_W-1:0] tol_g,
                           logic [CHAN_W-1:0] tol_b);
    logic [DIM_W-CHAN_W-1:0] junk;
    junk = (DIM_W-CHAN_W)'($urandom_range(31));
    write_reg(REG_FRAME_WIDTH, frame_w);
    write_reg(REG_FRAME_HEIGHT, frame_h);
    write_reg(REG_TOLERANCE_RED, {junk, tol_r});
    write_reg(REG_TOLERANCE_GREEN, {~junk, tol_g});
    write_reg(REG_TOLERANCE_BLUE, {junk, tol_b});
    cfg_valid <= 1'b0;
  endtask

  function automatic ckre_pix_t rgb(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                    logic [CHAN_W-1:0] b);
    ckre_pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan(int lo, int hi);
    return CHAN_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan(logic [CHAN_W-1:0] lo, logic [CHAN_W-1:0] hi,
                                                   chan_pick_t how);
    case (how)
      CH_INSIDE: return rand_chan(lo, hi);
      CH_EDGE:   return $urandom_range(1) ? lo : hi;
      CH_OUTSIDE: begin
        if (lo == '0 && hi == CHAN_MAX) return rand_chan(0, 255);
        if (lo == '0) return hi + 8'd1;
        if (hi == CHAN_MAX) return lo - 8'd1;
        return $urandom_range(1) ? lo - 8'd1 : hi + 8'd1;
      end
      default: return rand_chan(0, 255);
    endcase
  endfunction

  function automatic ckre_pix_t make_pixel();
    chan_pick_t how_r, how_g, how_b;
    int         mode;
    if (at_frame_start()) begin
      case ($urandom_range(7))
        0:       return rgb(8'h00, 8'h00, 8'h00);
        1:       return rgb(CHAN_MAX, CHAN_MAX, CHAN_MAX);
        default: return rgb(rand_chan(0, 255), rand_chan(0, 255), rand_chan(0, 255));
      endcase
    end
    mode = $urandom_range(99);
    if (mode < 40) begin
      how_r = CH_INSIDE; how_g = CH_INSIDE; how_b = CH_INSIDE;
    end else if (mode < 55) begin
      how_r = CH_EDGE; how_g = CH_EDGE; how_b = CH_EDGE;
    end else if (mode < 75) begin
      how_r = $urandom_range(1) ? CH_INSIDE : CH_EDGE;
      how_g = $urandom_range(1) ? CH_INSIDE : CH_EDGE;
      how_b = $urandom_range(1) ? CH_INSIDE : CH_EDGE;
      case ($urandom_range(2))
        0:       how_r = CH_OUTSIDE;
        1:       how_g = CH_OUTSIDE;
        default: how_b = CH_OUTSIDE;
      endcase
    end else begin
      how_r = CH_ANY; how_g = CH_ANY; how_b = CH_ANY;
    end
    return rgb(pick_chan(band_lo_r, band_hi_r, how_r), pick_chan(band_lo_g, band_hi_g, how_g),
               pick_chan(band_lo_b, band_hi_b, how_b));
  endfunction

  function automatic logic [DIM_W-1:0] random_dim(int most);
    case ($urandom_range(9))
      0:       return '0;
      1:       return DIM_W'(1);
      default: return DIM_W'($urandom_range(most, 2));
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] random_tol();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CHAN_MAX;
      2, 3:    return rand_chan(0, 40);
      default: return rand_chan(0, 255);
    endcase
  endfunction

  task automatic configure_random();
    configure(random_dim(12), random_dim(5), random_tol(), random_tol(), random_tol());
  endtask

  // reset register values: full-size frame, zero tolerance
  task automatic test_reset_defaults();
    send_pixel(rgb(8'd10, 8'd20, 8'd30));
    send_pixel(rgb(8'd10, 8'd20, 8'd30));
    send_pixel(rgb(8'd11, 8'd20, 8'd30));
    send_pixel(rgb(8'd10, 8'd20, 8'd30));
    settle();
  endtask

  // width shrunk below the current column, then the rest of a two-row frame
  task automatic test_midframe_resize();
    configure(DIM_W'(3), DIM_W'(2), 8'd0, 8'd0, 8'd0);
    send_pixel(rgb(8'd10, 8'd20, 8'd31));
    send_pixel(rgb(8'd10, 8'd20, 8'd30));
    send_pixel(rgb(8'd0, 8'd0, 8'd0));
    send_pixel(rgb(8'd255, 8'd255, 8'd255));
    settle();
  endtask

  // band ends, saturation at both sides, run open at frame end
  task automatic test_band_edges();
    configure(DIM_W'(6), DIM_W'(1), 8'd10, 8'd0, 8'd255);
    send_pixel(rgb(8'd5, 8'd250, 8'd128));
    send_pixel(rgb(8'd0, 8'd250, 8'd0));
    send_pixel(rgb(8'd15, 8'd250, 8'd255));
    send_pixel(rgb(8'd16, 8'd250, 8'd0));
    send_pixel(rgb(8'd15, 8'd249, 8'd0));
    send_pixel(rgb(8'd15, 8'd251, 8'd255));
    send_pixel(rgb(8'd250, 8'd0, 8'd255));
    send_pixel(rgb(8'd255, 8'd0, 8'd0));
    send_pixel(rgb(8'd240, 8'd0, 8'd0));
    send_pixel(rgb(8'd239, 8'd0, 8'd0));
    send_pixel(rgb(8'd240, 8'd1, 8'd0));
    send_pixel(rgb(8'd255, 8'd0, 8'd255));
    settle();
  endtask

  // empty frames; a tolerance cut mid-frame must wait for the next key
  task automatic test_empty_frames();
    configure(DIM_W'(2), DIM_W'(2), CHAN_MAX, CHAN_MAX, CHAN_MAX);
    send_pixel(rgb(8'd128, 8'd128, 8'd128));
    send_pixel(rgb(8'd0, 8'd255, 8'd0));
    settle();
    configure(DIM_W'(2), DIM_W'(2), 8'd0, 8'd0, 8'd0);
    send_pixel(rgb(8'd255, 8'd0, 8'd255));
    send_pixel(rgb(8'd1, 8'd2, 8'd3));
    settle();
    configure('0, '0, 8'd0, 8'd0, 8'd0);
    send_pixel(rgb(8'd77, 8'd66, 8'd55));
    settle();
  endtask

  task automatic test_random_frames();
    int sent;
    int split_at;
    int k;
    sent      = 0;
    stall_pct = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= QUIET_ITEMS) stall_pct = 9;
      if (sent == 0 || $urandom_range(3) == 0) begin
        settle();
        configure_random();
      end
      split_at = ($urandom_range(4) == 0) ? $urandom_range(8, 1) : -1;
      k = 0;
      do begin
        if (k == split_at) begin
          settle();
          configure_random();
        end
        send_pixel(make_pixel());
        k++;
        sent++;
      end while (!at_frame_start());
    end
  endtask

  // over-range width, then over-range height; a later resize closes each frame
  task automatic test_largest_frames();
    ckre_pix_t key_pix, odd_pix;
    int        k;
    for (int pass = 0; pass < 2; pass++) begin
      settle();
      if (pass == 0) configure(DIM_ALL_ONES, DIM_W'(1), 8'd0, 8'd0, 8'd0);
      else configure('0, DIM_ALL_ONES, 8'd0, 8'd0, 8'd0);
      key_pix = rgb(rand_chan(0, 255), rand_chan(0, 255), rand_chan(0, 255));
      odd_pix = key_pix;
      odd_pix.red = key_pix.red ^ 8'h80;
      for (k = 0; k < OVER_ITEMS; k++) begin
        send_pixel((k % 7 == 5) ? odd_pix : key_pix);
      end
      settle();
      if (pass == 0) configure(DIM_W'(OVER_ITEMS + 1), DIM_W'(1), 8'd0, 8'd0, 8'd0);
      else configure('0, DIM_W'(OVER_ITEMS + 1), 8'd0, 8'd0, 8'd0);
      do begin
        send_pixel(odd_pix);
      end while (!at_frame_start());
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_midframe_resize();
    test_band_edges();
    test_empty_frames();
    test_random_frames();
    test_largest_frames();
    settle();
    $display("Ran %0d pixels: band edges, mid-frame resizes, empty and over-range frames.",
             n_pixels);
    $display("Checked %0d run rectangles and %0d bounding boxes.", n_runs, n_boxes);
    if (n_fail == 0) begin
      $display("color_key_run_extractor_core_test OK");
    end else begin
      $display("color_key_run_extractor_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding.", pending_regions.size());
    $display("color_key_run_extractor_core_test NOT OK");
    $finish;
  end

endmodule

### color_key_run_extractor_core.f
design/ckre_pkg.sv
design/ckre_fifo.sv
design/ckre_front.sv
design/ckre_back.sv
design/color_key_run_extractor_core.sv
tb/color_key_run_extractor_core_test.sv
